[rtl/lspi_pkg.sv]
// ----------------------------------------------------------------------------
// lspi_pkg: shared types and codes for the lift and span pose interlock
// Holds the operation, zone, command and state codes and the item structs.
// ----------------------------------------------------------------------------
package lspi_pkg;

   // Operation codes carried in the request tuser.
   localparam logic [1:0] OP_POSE   = 2'd0;
   localparam logic [1:0] OP_STOP   = 2'd1;
   localparam logic [1:0] OP_MANUAL = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Pose codes.
   localparam logic [1:0] POSE_UNKNOWN = 2'd0;
   localparam logic [1:0] POSE_SLEEP   = 2'd1;
   localparam logic [1:0] POSE_LOUNGE  = 2'd2;

   // Lift zone codes.
   localparam logic [2:0] ZONE_LOWER_LIMIT  = 3'd1;
   localparam logic [2:0] ZONE_BELOW_SAFE   = 3'd2;
   localparam logic [2:0] ZONE_IN_SAFE      = 3'd3;
   localparam logic [2:0] ZONE_ABOVE_SAFE   = 3'd4;
   localparam logic [2:0] ZONE_ABOVE_CEIL   = 3'd5;
   localparam logic [2:0] ZONE_UPPER_LIMIT  = 3'd6;

   // Span position codes.
   localparam logic [1:0] SPAN_RETRACTED = 2'd1;
   localparam logic [1:0] SPAN_EXTENDED  = 2'd2;

   // Lift commands.
   localparam logic [1:0] LIFT_SLEEP = 2'd0;
   localparam logic [1:0] LIFT_RAISE = 2'd1;
   localparam logic [1:0] LIFT_LOWER = 2'd2;
   // Span commands.
   localparam logic [1:0] SPAN_SLEEP   = 2'd0;
   localparam logic [1:0] SPAN_EXTEND  = 2'd1;
   localparam logic [1:0] SPAN_RETRACT = 2'd2;
   // No command issued, shared by both drivers.
   localparam logic [1:0] CMD_NONE = 2'd3;

   // Machine states.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MOVING  = 3'd1;
   localparam logic [2:0] ST_DONE    = 3'd2;
   localparam logic [2:0] ST_ABORTED = 3'd3;
   localparam logic [2:0] ST_ERROR   = 3'd4;

   // Result codes.
   localparam logic signed [7:0] RC_DONE     = 8'sd0;
   localparam logic signed [7:0] RC_PROGRESS = 8'sd1;

   // Span and lift may move together inside the safe zone.
   localparam logic MOVE_TOGETHER_IN_SAFE = 1'b1;

   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        want_pose;
      logic [2:0]        lift_zone;
      logic [1:0]        span_position;
      logic signed [7:0] lift_status;
      logic signed [7:0] span_status;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        lift_command;
      logic [1:0]        span_command;
      logic signed [7:0] result_code;
      logic [2:0]        machine_state;
      logic [1:0]        present_pose;
      logic [1:0]        goal_pose;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0] run_state;
      logic [1:0] reached_pose;
      logic [1:0] aim_pose;
      logic       span_moving_while_lowering;
      logic       span_must_finish_first;
   } ctl_state_type;

endpackage

[rtl/lift_span_pose_interlock.sv]
// ----------------------------------------------------------------------------
// lift_span_pose_interlock: lift and folding-span pose interlock
// Registered poll stage, decision table and result register with state.
// ----------------------------------------------------------------------------
// Each poll transfer asks the block to move toward the sleep or lounge pose,
// to stop, or to hand over to manual control, and returns exactly one result
// transfer with the lift and span commands, a signed result code and the
// state after the update. The block sustains one transfer per clock cycle
// while rsp_tready holds no result back: a poll is captured in an input
// register, goes through the decision table and lands in the result
// register together with the control state update, where it is offered
// until rsp_tready takes it. The control state loop (state registers through
// the decision table and back) closes without an extra register, which is
// what sets the one-per-cycle rate. A new poll is taken while a finished
// result still waits for rsp_tready, as long as the input register is empty.
// The bad-state code is written through csr_wr_en and csr_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
module lift_span_pose_interlock (
   input  logic        clock,
   input  logic        reset,
   // Poll channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // want_pose[1:0], lift_zone[4:2], span_position[6:5], lift_status[14:7],
   // span_status[22:15], zero[23].
   input  logic [23:0] req_tdata,
   // op[1:0].
   input  logic [1:0]  req_tuser,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // lift_command[1:0], span_command[3:2], result_code[11:4],
   // machine_state[14:12], present_pose[16:15], goal_pose[18:17], zero[23:19].
   output logic [23:0] rsp_tdata,
   // Configuration: bad_state_code.
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   // Configured bad-state code, reset to -1.
   logic signed [7:0]       bad_code_ff;

   // Input stage.
   logic                    s1_vld_ff;
   lspi_pkg::req_item_type  s1_item_ff;
   lspi_pkg::req_item_type  s1_item_in;

   // Control state and result register.
   lspi_pkg::ctl_state_type state_ff;
   lspi_pkg::ctl_state_type state_in;
   logic                    rsp_vld_ff;
   lspi_pkg::rsp_item_type  rsp_item_ff;
   lspi_pkg::rsp_item_type  rsp_item_in;

   logic                    advance;

   // The input stage moves on whenever the result register is free or
   // being emptied in this cycle.
   assign advance    = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || advance;

   assign s1_item_in.op            = req_tuser;
   assign s1_item_in.want_pose     = req_tdata[1:0];
   assign s1_item_in.lift_zone     = req_tdata[4:2];
   assign s1_item_in.span_position = req_tdata[6:5];
   assign s1_item_in.lift_status   = req_tdata[14:7];
   assign s1_item_in.span_status   = req_tdata[22:15];

   lspi_decide u_decide (
      .item           (s1_item_ff),
      .cur            (state_ff),
      .bad_state_code (bad_code_ff),
      .rsp            (rsp_item_in),
      .nxt            (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bad_code_ff <= -8'sd1;
      end else if (csr_wr_en) begin
         bad_code_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_tready) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff <= s1_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.run_state                  <= lspi_pkg::ST_IDLE;
         state_ff.reached_pose               <= lspi_pkg::POSE_UNKNOWN;
         state_ff.aim_pose                   <= lspi_pkg::POSE_UNKNOWN;
         state_ff.span_moving_while_lowering <= 1'b0;
         state_ff.span_must_finish_first     <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, rsp_item_ff.goal_pose, rsp_item_ff.present_pose,
                        rsp_item_ff.machine_state, rsp_item_ff.result_code,
                        rsp_item_ff.span_command, rsp_item_ff.lift_command};

   // The control state changes only when a poll is decided.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("control state changed without a decided poll");

   // A decided poll always leaves a result behind.
   a_result_after_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("decided poll produced no result");

   // The poll side stalls only when both stages are full and blocked.
   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_vld_ff && rsp_vld_ff && !rsp_tready))
      else $error("poll side stalled without a full pipeline");

   // The lift is never left without a command while the span gets one.
   a_cmd_pairing: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_item_ff.lift_command == lspi_pkg::CMD_NONE)
         |-> (rsp_item_ff.span_command == lspi_pkg::CMD_NONE))
      else $error("span command issued without a lift command");

endmodule

[rtl/lspi_decide.sv]
// ----------------------------------------------------------------------------
// lspi_decide: decision table of the pose interlock
// Maps one poll item and the current control state to the driver commands,
// the result code and the next control state.
// ----------------------------------------------------------------------------
module lspi_decide (
   input  lspi_pkg::req_item_type  item,
   input  lspi_pkg::ctl_state_type cur,
   input  logic signed [7:0]       bad_state_code,
   output lspi_pkg::rsp_item_type  rsp,
   output lspi_pkg::ctl_state_type nxt
);

   always_comb begin
      logic [1:0]        lc;
      logic [1:0]        sc;
      logic              done_here;
      logic              ext;
      logic              ret;
      logic signed [7:0] le;
      logic signed [7:0] se;
      logic signed [7:0] rc;

      nxt       = cur;
      lc        = lspi_pkg::CMD_NONE;
      sc        = lspi_pkg::CMD_NONE;
      rc        = lspi_pkg::RC_DONE;
      done_here = 1'b0;
      ext       = (item.span_position == lspi_pkg::SPAN_EXTENDED);
      ret       = (item.span_position == lspi_pkg::SPAN_RETRACTED);
      le        = bad_state_code;
      se        = bad_state_code;

      unique case (item.op)
         lspi_pkg::OP_POSE: begin
            // A fresh target restarts the move and drops both flags.
            if (cur.run_state != lspi_pkg::ST_MOVING || item.want_pose != cur.aim_pose) begin
               nxt.reached_pose               = lspi_pkg::POSE_UNKNOWN;
               nxt.aim_pose                   = item.want_pose;
               nxt.span_moving_while_lowering = 1'b0;
               nxt.span_must_finish_first     = 1'b0;
            end
            nxt.run_state = lspi_pkg::ST_MOVING;

            if (item.want_pose == lspi_pkg::POSE_SLEEP) begin
               unique case (item.lift_zone)
                  lspi_pkg::ZONE_LOWER_LIMIT: begin
                     if (ext) begin
                        lc = lspi_pkg::LIFT_SLEEP;
                        sc = lspi_pkg::SPAN_SLEEP;
                        done_here = 1'b1;
                     end else begin
                        lc = lspi_pkg::LIFT_RAISE;
                        sc = lspi_pkg::SPAN_SLEEP;
                        nxt.span_must_finish_first = 1'b1;
                     end
                  end
                  lspi_pkg::ZONE_BELOW_SAFE: begin
                     if (ext) begin
                        lc = lspi_pkg::LIFT_LOWER;
                        sc = lspi_pkg::SPAN_SLEEP;
                     end else if (lspi_pkg::MOVE_TOGETHER_IN_SAFE &&
                                  nxt.span_moving_while_lowering) begin
                        lc = lspi_pkg::LIFT_SLEEP;
                        sc = lspi_pkg::SPAN_EXTEND;
                     end else begin
                        lc = lspi_pkg::LIFT_RAISE;
                        sc = lspi_pkg::SPAN_SLEEP;
                        nxt.span_must_finish_first = 1'b1;
                     end
                  end
                  lspi_pkg::ZONE_IN_SAFE: begin
                     if (ext) begin
                        lc = lspi_pkg::LIFT_LOWER;
                        sc = lspi_pkg::SPAN_SLEEP;
                     end else begin
                        if (!lspi_pkg::MOVE_TOGETHER_IN_SAFE || nxt.span_must_finish_first) begin
                           lc = lspi_pkg::LIFT_SLEEP;
                        end else begin
                           lc = lspi_pkg::LIFT_LOWER;
                           nxt.span_moving_while_lowering = 1'b1;
                        end
                        sc = lspi_pkg::SPAN_EXTEND;
                     end
                  end
                  lspi_pkg::ZONE_ABOVE_SAFE, lspi_pkg::ZONE_ABOVE_CEIL,
                  lspi_pkg::ZONE_UPPER_LIMIT: begin
                     lc = lspi_pkg::LIFT_LOWER;
                     sc = lspi_pkg::SPAN_SLEEP;
                  end
                  default: begin
                  end
               endcase
            end else if (item.want_pose == lspi_pkg::POSE_LOUNGE) begin
               unique case (item.lift_zone)
                  lspi_pkg::ZONE_LOWER_LIMIT, lspi_pkg::ZONE_BELOW_SAFE: begin
                     lc = lspi_pkg::LIFT_RAISE;
                     sc = lspi_pkg::SPAN_SLEEP;
                  end
                  lspi_pkg::ZONE_IN_SAFE: begin
                     if (ret) begin
                        lc = lspi_pkg::LIFT_RAISE;
                        sc = lspi_pkg::SPAN_SLEEP;
                     end else begin
                        lc = lspi_pkg::MOVE_TOGETHER_IN_SAFE ? lspi_pkg::LIFT_RAISE
                                                             : lspi_pkg::LIFT_SLEEP;
                        sc = lspi_pkg::SPAN_RETRACT;
                     end
                  end
                  lspi_pkg::ZONE_ABOVE_SAFE: begin
                     if (ret) begin
                        lc = lspi_pkg::LIFT_RAISE;
                        sc = lspi_pkg::SPAN_SLEEP;
                     end else begin
                        lc = lspi_pkg::LIFT_SLEEP;
                        sc = lspi_pkg::SPAN_RETRACT;
                     end
                  end
                  lspi_pkg::ZONE_ABOVE_CEIL, lspi_pkg::ZONE_UPPER_LIMIT: begin
                     lc = lspi_pkg::LIFT_SLEEP;
                     if (ret) begin
                        sc = lspi_pkg::SPAN_SLEEP;
                        done_here = 1'b1;
                     end else begin
                        sc = lspi_pkg::SPAN_RETRACT;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            // With no command issued the configured code stands in for both replies.
            if (lc != lspi_pkg::CMD_NONE) begin
               le = item.lift_status;
               se = item.span_status;
            end

            if (le[7]) begin
               nxt.run_state = lspi_pkg::ST_ERROR;
               rc = le;
            end else if (se[7]) begin
               nxt.run_state = lspi_pkg::ST_ERROR;
               rc = se;
            end else if (le != 8'sd0 || se != 8'sd0 || !done_here) begin
               rc = lspi_pkg::RC_PROGRESS;
            end else begin
               nxt.reached_pose = item.want_pose;
               nxt.run_state    = lspi_pkg::ST_DONE;
               rc = lspi_pkg::RC_DONE;
            end
         end
         lspi_pkg::OP_STOP: begin
            nxt.aim_pose = lspi_pkg::POSE_UNKNOWN;
            if (cur.run_state == lspi_pkg::ST_MOVING) begin
               nxt.run_state = lspi_pkg::ST_ABORTED;
            end
            lc = lspi_pkg::LIFT_SLEEP;
            sc = lspi_pkg::SPAN_SLEEP;
            // A busy driver outranks an error on the other one.
            if ((!item.lift_status[7] && item.lift_status != 8'sd0) ||
                (!item.span_status[7] && item.span_status != 8'sd0)) begin
               rc = lspi_pkg::RC_PROGRESS;
            end else if (item.lift_status[7]) begin
               nxt.run_state = lspi_pkg::ST_ERROR;
               rc = item.lift_status;
            end else if (item.span_status[7]) begin
               nxt.run_state = lspi_pkg::ST_ERROR;
               rc = item.span_status;
            end else begin
               rc = lspi_pkg::RC_DONE;
            end
         end
         lspi_pkg::OP_MANUAL: begin
            nxt.reached_pose = lspi_pkg::POSE_UNKNOWN;
            nxt.aim_pose     = lspi_pkg::POSE_UNKNOWN;
            nxt.run_state    = lspi_pkg::ST_ABORTED;
         end
         lspi_pkg::OP_UNUSED: begin
         end
      endcase

      rsp.lift_command  = lc;
      rsp.span_command  = sc;
      rsp.result_code   = rc;
      rsp.machine_state = nxt.run_state;
      rsp.present_pose  = nxt.reached_pose;
      rsp.goal_pose     = nxt.aim_pose;
   end

endmodule
